@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the transceiver core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/tut_pkg.sv @@
// Types and constants of the timer UART transceiver core.
`default_nettype none

package tut_pkg;

    // Configuration register indexes and widths
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TIME = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BIT_TIME_RESET      = 16'd104;
    localparam logic [CFG_DATA_W-1:0] HALF_BIT_TIME_RESET = 16'd52;

    // Frame: start, eight data bits, stop
    localparam int unsigned FRAME_W = 10;
    localparam logic [3:0]  FRAME_BITS = 4'd10;

    // Transceiver mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_TX   = 3'b010,
        MODE_RX   = 3'b100
    } tut_mode_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] bit_period;
        logic [CFG_DATA_W-1:0] half_period;
    } tut_cfg_t;

    typedef struct packed {
        logic       rx_in;
        logic       tx_start;
        logic [7:0] tx_byte;
    } tut_item_t;

    typedef struct packed {
        logic       tx_out;
        logic       tx_busy;
        logic       rx_busy;
        logic       rx_valid;
        logic [7:0] rx_data;
    } tut_result_t;

endpackage

`default_nettype wire

@@ rtl/core/tut_in_if.sv @@
// Input channel: one timer tick word with line level and transmit request.
`default_nettype none

interface tut_in_if;
    logic       valid;
    logic       ready;
    logic       rx_in;
    logic       tx_start;
    logic [7:0] tx_byte;

    modport source (output valid, output rx_in, output tx_start, output tx_byte,
                    input ready);
    modport sink (input valid, input rx_in, input tx_start, input tx_byte,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/tut_out_if.sv @@
// Output channel: line and status word produced for every tick.
`default_nettype none

interface tut_out_if;
    logic       valid;
    logic       ready;
    logic       tx_out;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_valid;
    logic [7:0] rx_data;

    modport source (output valid, output tx_out, output tx_busy, output rx_busy,
                    output rx_valid, output rx_data, input ready);
    modport sink (input valid, input tx_out, input tx_busy, input rx_busy,
                  input rx_valid, input rx_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tut_engine.sv @@
// Transceiver state and single-tick update: bit timer, tx shifter, rx sampler.
`default_nettype none

module tut_engine
    import tut_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire tut_item_t   item,
    input  wire tut_cfg_t    cfg,
    output tut_result_t      result
);

    tut_mode_t              mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]             bits_reg, bits_next;
    logic [FRAME_W-1:0]     tx_frame_reg, tx_frame_next;
    logic [FRAME_W-1:0]     rx_frame_reg, rx_frame_next;
    logic                   line_reg, line_next;
    logic                   last_rx_reg;

    logic [COUNT_WIDTH+CFG_DATA_W-1:0] bit_wide, half_wide;
    logic [COUNT_WIDTH-1:0] bit_iv, half_iv;
    logic                   fell;
    logic                   tick_due;
    logic [FRAME_W-1:0]     rx_shift;
    logic [3:0]             bits_dec;

    // Intervals masked to the counter width; zero acts as one tick
    assign bit_wide  = {{COUNT_WIDTH{1'b0}}, cfg.bit_period};
    assign half_wide = {{COUNT_WIDTH{1'b0}}, cfg.half_period};
    assign bit_iv  = (bit_wide[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
                                                      : bit_wide[COUNT_WIDTH-1:0];
    assign half_iv = (half_wide[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
                                                        : half_wide[COUNT_WIDTH-1:0];

    assign fell     = last_rx_reg && !item.rx_in;
    assign tick_due = (tick_reg <= COUNT_WIDTH'(1));
    assign rx_shift = {item.rx_in, rx_frame_reg[FRAME_W-1:1]};
    assign bits_dec = bits_reg - 4'd1;

    // Next state for one tick
    always_comb
    begin
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        bits_next     = bits_reg;
        tx_frame_next = tx_frame_reg;
        rx_frame_next = rx_frame_reg;
        line_next     = line_reg;
        result        = '0;

        if (mode_reg != MODE_RX && fell)
        begin
            // start edge: abandon any transmit and arm the first sample
            mode_next     = MODE_RX;
            line_next     = 1'b1;
            rx_frame_next = '0;
            bits_next     = FRAME_BITS;
            tick_next     = half_iv;
        end
        else
        begin
            case (mode_reg)
                MODE_RX:
                begin
                    if (tick_due)
                    begin
                        rx_frame_next = rx_shift;
                        bits_next     = bits_dec;
                        tick_next     = bit_iv;
                        if (bits_dec == 4'd0)
                        begin
                            mode_next = MODE_IDLE;
                            tick_next = '0;
                            // good framing: start low, stop high
                            if (!rx_shift[0] && rx_shift[FRAME_W-1])
                            begin
                                result.rx_valid = 1'b1;
                                result.rx_data  = rx_shift[8:1];
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg - COUNT_WIDTH'(1);
                    end
                end
                MODE_TX:
                begin
                    if (tick_due)
                    begin
                        if (bits_reg == 4'd0)
                        begin
                            mode_next = MODE_IDLE;
                            tick_next = '0;
                            line_next = 1'b1;
                        end
                        else
                        begin
                            line_next     = tx_frame_reg[0];
                            tx_frame_next = {1'b0, tx_frame_reg[FRAME_W-1:1]};
                            bits_next     = bits_dec;
                            tick_next     = bit_iv;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg - COUNT_WIDTH'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (item.tx_start)
                    begin
                        mode_next     = MODE_TX;
                        tx_frame_next = {1'b1, item.tx_byte, 1'b0};
                        bits_next     = FRAME_BITS;
                        tick_next     = bit_iv;
                        line_next     = 1'b1;
                    end
                end
            endcase
        end

        result.tx_out  = line_next;
        result.tx_busy = (mode_next == MODE_TX);
        result.rx_busy = (mode_next == MODE_RX);
    end

    // State registers, updated once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            tick_reg     <= '0;
            bits_reg     <= '0;
            tx_frame_reg <= '0;
            rx_frame_reg <= '0;
            line_reg     <= 1'b1;
            last_rx_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            bits_reg     <= bits_next;
            tx_frame_reg <= tx_frame_next;
            rx_frame_reg <= rx_frame_next;
            line_reg     <= line_next;
            last_rx_reg  <= item.rx_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/timer_uart_transceiver_core.sv @@
// A word accepted into the input register has its result registered in the
// result register. Throughput: one word per cycle while the result register is
// empty or taken; the state update is a combinational pass through the engine
// between the input register and the result register.
// Reset (rst_n, async low): line idle high, mode idle, timer and shifters cleared,
// bit period 104 and half-bit period 52, both pipeline stages empty.
`default_nettype none

module timer_uart_transceiver_core
    import tut_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tut_in_if.sink                     req,
    tut_out_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    tut_cfg_t    cfg_reg;
    logic        in_valid_reg;
    tut_item_t   in_item_reg;
    logic        out_valid_reg;
    tut_result_t out_word_reg;
    tut_result_t result;
    logic        advance;
    logic        step;

    // Pipeline flow: result stage frees when empty or taken
    assign advance   = !out_valid_reg || rsp.ready;
    assign step      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period  <= BIT_TIME_RESET;
            cfg_reg.half_period <= HALF_BIT_TIME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_TIME:      cfg_reg.bit_period  <= cfg_data;
                CFG_HALF_BIT_TIME: cfg_reg.half_period <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.rx_in    <= req.rx_in;
            in_item_reg.tx_start <= req.tx_start;
            in_item_reg.tx_byte  <= req.tx_byte;
        end
    end

    tut_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_word_reg <= result;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.tx_out   = out_word_reg.tx_out;
    assign rsp.tx_busy  = out_word_reg.tx_busy;
    assign rsp.rx_busy  = out_word_reg.rx_busy;
    assign rsp.rx_valid = out_word_reg.rx_valid;
    assign rsp.rx_data  = out_word_reg.rx_data;

endmodule

`default_nettype wire

@@ rtl/core/tut_checker.sv @@
// Port-level checks of the transceiver core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tut_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       tx_out,
    input wire logic       tx_busy,
    input wire logic       rx_busy,
    input wire logic       rx_valid,
    input wire logic [7:0] rx_data
);

    // Half duplex: never transmitting and receiving at once
    `ASSERT_NEVER(a_half_duplex, clk, rst_n, rsp_valid && tx_busy && rx_busy)

    // A received byte is reported only as the frame closes
    `ASSERT_IMPLIES(a_valid_idle, clk, rst_n, rsp_valid && rx_valid, !rx_busy && !tx_busy)

    // Data bus is quiet without a received byte
    `ASSERT_IMPLIES(a_data_quiet, clk, rst_n, rsp_valid && !rx_valid, rx_data == 8'd0)

    // Transmit line sits at mark while receiving
    `ASSERT_IMPLIES(a_line_idle_rx, clk, rst_n, rsp_valid && rx_busy, tx_out)

    // Receive pulse lasts a single word
    `ASSERT_IMPLIES(a_valid_pulse, clk, rst_n,
        rsp_valid && rsp_ready && rx_valid ##1 rsp_valid, !rx_valid)

endmodule

bind timer_uart_transceiver_core tut_checker u_tut_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .tx_out    (rsp.tx_out),
    .tx_busy   (rsp.tx_busy),
    .rx_busy   (rsp.rx_busy),
    .rx_valid  (rsp.rx_valid),
    .rx_data   (rsp.rx_data)
);

`default_nettype wire
